// File: rtl/ogua_pkg.sv
// ----------------------------------------------------------------------------
// ogua_pkg
// Shared types and constants of the occupancy grid update averager.
// ----------------------------------------------------------------------------
package ogua_pkg;

  localparam int CFG_W = 9;
  localparam int VAL_W = 8;
  localparam int CNT_W = 15;
  localparam int SUM_W = 24;
  localparam int POS_W = 18;
  localparam int DIV_W = 23;

  localparam logic [CNT_W-1:0] COUNT_MAX = 15'h7FFF;
  localparam logic [VAL_W-1:0] FREE_VALUE = 8'd100;
  localparam logic [VAL_W-1:0] MARK_OCCUPIED = 8'hFF;
  localparam logic [VAL_W-1:0] MARK_FREE = 8'h00;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_NOT_LOADED = 3'd1;
  localparam logic [2:0] ST_FULL_PATCH = 3'd2;
  localparam logic [2:0] ST_OUTSIDE    = 3'd3;
  localparam logic [2:0] ST_LOADED     = 3'd4;
  localparam logic [2:0] ST_SATURATED  = 3'd5;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PATCH = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_UPDATE,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [2:0]       status;
    logic             ready;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_LOAD_DIV,
    BK_UPD_WR,
    BK_QRY_EVAL,
    BK_QRY_DIV
  } back_state_e;

endpackage

// File: rtl/ogua_ram.sv
// ----------------------------------------------------------------------------
// ogua_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ogua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/ogua_div.sv
// ----------------------------------------------------------------------------
// ogua_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ogua_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ogua_pkg::DIV_W-1:0]   dividend_i,
  input  logic [ogua_pkg::CNT_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [ogua_pkg::DIV_W-1:0]   quot_o,
  output logic [ogua_pkg::CNT_W-1:0]   rem_o
);

  localparam int DW = ogua_pkg::DIV_W;
  localparam int NW = ogua_pkg::CNT_W;
  localparam int CW = $clog2(DW + 1);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] dvs_q, dvs_d;
  logic [NW:0]   trial;
  logic [NW:0]   diff;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[DW-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(DW);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (!diff[NW]) begin
        rem_d = diff[NW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[NW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/ogua_queue.sv
// ----------------------------------------------------------------------------
// ogua_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ogua_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       fill_q, fill_d;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (fill_q == 2'd0);
  assign full_o  = (fill_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d   = do_push ? ~wr_q : wr_q;
    rd_d   = do_pop ? ~rd_q : rd_q;
    fill_d = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ogua_front.sv
// ----------------------------------------------------------------------------
// ogua_front
// Accepts items, tracks load and patch positions, classifies each item.
// ----------------------------------------------------------------------------
module ogua_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int FW = (AW > ogua_pkg::POS_W) ? AW : ogua_pkg::POS_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [1:0]            action_i,
  input  logic signed [7:0]     cell_value_i,
  input  logic                  patch_first_i,
  input  logic signed [8:0]     patch_x_i,
  input  logic signed [8:0]     patch_y_i,
  input  logic [8:0]            patch_width_i,
  input  logic [8:0]            patch_height_i,
  input  logic [7:0]            query_x_i,
  input  logic [7:0]            query_y_i,
  input  logic [8:0]            map_width_i,
  input  logic [8:0]            map_height_i,
  output logic                  push_o,
  output ogua_pkg::cmd_t        cmd_o,
  output logic [FW-1:0]         addr_o,
  output logic [8:0]            w_o
);

  localparam int PW = ogua_pkg::POS_W;

  logic          loaded_q, loaded_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    col_q, col_d;
  logic [8:0]    row_q, row_d;
  logic [8:0]    w, h, pw, ph;
  logic [PW-1:0] wh;
  logic [7:0]    col_s;
  logic [8:0]    row_s;
  logic [8:0]    col_n;
  logic [10:0]   x_s, y_s;
  logic          x_out, y_out;
  logic [FW+9:0] pa, qa;

  always_comb begin
    if (map_width_i == 9'd0) begin
      w = 9'd1;
    end else if (32'(map_width_i) > 32'(MAX_WIDTH)) begin
      w = 9'(MAX_WIDTH);
    end else begin
      w = map_width_i;
    end
    if (map_height_i == 9'd0) begin
      h = 9'd1;
    end else if (32'(map_height_i) > 32'(MAX_HEIGHT)) begin
      h = 9'(MAX_HEIGHT);
    end else begin
      h = map_height_i;
    end
    if (patch_width_i == 9'd0) begin
      pw = 9'd1;
    end else if (patch_width_i > 9'd256) begin
      pw = 9'd256;
    end else begin
      pw = patch_width_i;
    end
    if (patch_height_i == 9'd0) begin
      ph = 9'd1;
    end else if (patch_height_i > 9'd256) begin
      ph = 9'd256;
    end else begin
      ph = patch_height_i;
    end
  end

  assign wh  = PW'(w) * PW'(h);
  assign w_o = w;

  always_comb begin
    col_s = patch_first_i ? 8'd0 : col_q;
    row_s = patch_first_i ? 9'd0 : row_q;
    if ({1'b0, col_s} >= pw) begin
      col_s = 8'd0;
    end
    col_n = {1'b0, col_s} + 9'd1;
    x_s   = {{2{patch_x_i[8]}}, patch_x_i} + {3'b000, col_s};
    y_s   = {{2{patch_y_i[8]}}, patch_y_i} + {2'b00, row_s};
    x_out = x_s[10] || (x_s[9:0] >= {1'b0, w});
    y_out = y_s[10] || (y_s[9:0] >= {1'b0, h});
    pa    = (FW+10)'(y_s[8:0]) * (FW+10)'(MAX_WIDTH) + (FW+10)'(x_s[8:0]);
    qa    = (FW+10)'(query_y_i) * (FW+10)'(MAX_WIDTH) + (FW+10)'(query_x_i);
  end

  always_comb begin
    cmd_o.op     = ogua_pkg::OP_NONE;
    cmd_o.status = ogua_pkg::ST_DONE;
    cmd_o.value  = cell_value_i;
    addr_o       = '0;
    loaded_d     = loaded_q;
    pos_d        = pos_q;
    col_d        = col_q;
    row_d        = row_q;
    unique case (ogua_pkg::action_e'(action_i))
      ogua_pkg::ACT_LOAD: begin
        if (loaded_q) begin
          cmd_o.status = ogua_pkg::ST_LOADED;
        end else if (pos_q >= wh) begin
          loaded_d     = 1'b1;
          cmd_o.status = ogua_pkg::ST_LOADED;
        end else begin
          cmd_o.op = ogua_pkg::OP_LOAD;
          addr_o   = FW'(pos_q);
          pos_d    = pos_q + PW'(1);
          if (pos_d >= wh) begin
            loaded_d = 1'b1;
          end
        end
      end
      ogua_pkg::ACT_PATCH: begin
        if (!loaded_q) begin
          cmd_o.status = ogua_pkg::ST_NOT_LOADED;
        end else if (pw == w && ph == h) begin
          cmd_o.status = ogua_pkg::ST_FULL_PATCH;
        end else if (x_out || y_out) begin
          cmd_o.status = ogua_pkg::ST_OUTSIDE;
        end else begin
          cmd_o.op = ogua_pkg::OP_UPDATE;
          addr_o   = pa[FW-1:0];
        end
        if (col_n >= pw) begin
          col_d = 8'd0;
          row_d = row_s + 9'd1;
        end else begin
          col_d = col_n[7:0];
          row_d = row_s;
        end
      end
      ogua_pkg::ACT_QUERY: begin
        if (!loaded_q) begin
          cmd_o.status = ogua_pkg::ST_NOT_LOADED;
        end else if ({1'b0, query_x_i} >= w || {1'b0, query_y_i} >= h) begin
          cmd_o.status = ogua_pkg::ST_OUTSIDE;
        end else begin
          cmd_o.op = ogua_pkg::OP_QUERY;
          addr_o   = qa[FW-1:0];
        end
      end
      ogua_pkg::ACT_NONE: begin
        cmd_o.status = ogua_pkg::ST_DONE;
      end
    endcase
    cmd_o.ready = loaded_d;
  end

  assign push_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      pos_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else if (accept_i) begin
      loaded_q <= loaded_d;
      pos_q    <= pos_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

// File: rtl/ogua_back.sv
// ----------------------------------------------------------------------------
// ogua_back
// Executes queued commands against the base and statistics memories.
// ----------------------------------------------------------------------------
module ogua_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW = $clog2(DEPTH),
  localparam int FW = (AW > ogua_pkg::POS_W) ? AW : ogua_pkg::POS_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  ogua_pkg::cmd_t        cmd_i,
  input  logic [FW-1:0]         addr_i,
  input  logic [8:0]            w_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  done_o,
  output logic [2:0]            status_o,
  output logic                  map_ready_o,
  output logic signed [7:0]     combined_value_o,
  output logic [7:0]            free_mark_o,
  output logic [14:0]           hit_count_o
);

  localparam int NW = ogua_pkg::CNT_W;
  localparam int SW = ogua_pkg::SUM_W;
  localparam int DW = ogua_pkg::DIV_W;
  localparam int VW = ogua_pkg::VAL_W;

  ogua_pkg::back_state_e state_q, state_d;
  ogua_pkg::cmd_t        cur_q;
  logic [FW-1:0]         addr_q;
  logic [8:0]            lx_q, ly_q, lw_q;
  logic [AW-1:0]         clr_q;

  logic                  base_we, base_re;
  logic [AW-1:0]         base_waddr;
  logic [VW-1:0]         base_rdata;
  logic                  st_we, st_re;
  logic [AW-1:0]         st_waddr;
  logic [SW+NW-1:0]      st_wdata, st_rdata;
  logic [SW-1:0]         sum_r;
  logic [NW-1:0]         cnt_r;
  logic [SW-1:0]         neg_sum;
  logic [FW+9:0]         ladr;
  logic                  load_match;
  logic                  qry_div;

  logic                  div_start, div_done;
  logic [DW-1:0]         div_dividend, div_quot;
  logic [NW-1:0]         div_divisor, div_rem;

  logic                  emit;
  logic [2:0]            em_status;
  logic [VW-1:0]         em_comb, em_free;
  logic [NW-1:0]         em_hits;
  logic [VW-1:0]         cval;

  logic                  done_q;
  logic [2:0]            status_q;
  logic                  ready_q;
  logic [VW-1:0]         comb_q, free_q;
  logic [NW-1:0]         hits_q;

  assign sum_r      = st_rdata[SW+NW-1:NW];
  assign cnt_r      = st_rdata[NW-1:0];
  assign neg_sum    = SW'(0) - sum_r;
  assign ladr       = (FW+10)'(ly_q) * (FW+10)'(MAX_WIDTH) + (FW+10)'(lx_q);
  assign load_match = (lw_q == w_i);
  assign qry_div    = (cnt_r != '0) && !sum_r[SW-1];

  ogua_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (base_waddr),
    .wdata_i (cur_q.value),
    .re_i    (base_re),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (base_rdata)
  );

  ogua_ram #(.WIDTH(SW + NW), .DEPTH(DEPTH)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (st_rdata)
  );

  assign div_dividend = (state_q == ogua_pkg::BK_EXEC) ?
                        DW'(addr_q[ogua_pkg::POS_W-1:0]) : sum_r[DW-1:0];
  assign div_divisor  = (state_q == ogua_pkg::BK_EXEC) ? NW'(w_i) : cnt_r;

  ogua_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ogua_pkg::BK_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = ogua_pkg::BK_IDLE;
      end
      ogua_pkg::BK_IDLE: begin
        if (!empty_i) state_d = ogua_pkg::BK_EXEC;
      end
      ogua_pkg::BK_EXEC: begin
        unique case (cur_q.op)
          ogua_pkg::OP_NONE:   state_d = ogua_pkg::BK_IDLE;
          ogua_pkg::OP_LOAD:   state_d = load_match ? ogua_pkg::BK_IDLE
                                                    : ogua_pkg::BK_LOAD_DIV;
          ogua_pkg::OP_UPDATE: state_d = ogua_pkg::BK_UPD_WR;
          ogua_pkg::OP_QUERY:  state_d = ogua_pkg::BK_QRY_EVAL;
        endcase
      end
      ogua_pkg::BK_LOAD_DIV: begin
        if (div_done) state_d = ogua_pkg::BK_EXEC;
      end
      ogua_pkg::BK_UPD_WR: begin
        state_d = ogua_pkg::BK_IDLE;
      end
      ogua_pkg::BK_QRY_EVAL: begin
        state_d = qry_div ? ogua_pkg::BK_QRY_DIV : ogua_pkg::BK_IDLE;
      end
      ogua_pkg::BK_QRY_DIV: begin
        if (div_done) state_d = ogua_pkg::BK_IDLE;
      end
      default: state_d = ogua_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o      = 1'b0;
    base_we    = 1'b0;
    base_re    = 1'b0;
    base_waddr = ladr[AW-1:0];
    st_we      = 1'b0;
    st_re      = 1'b0;
    st_waddr   = addr_q[AW-1:0];
    st_wdata   = {sum_r + {{(SW-VW){cur_q.value[VW-1]}}, cur_q.value}, cnt_r + NW'(1)};
    div_start  = 1'b0;
    emit       = 1'b0;
    em_status  = cur_q.status;
    em_comb    = '0;
    em_free    = '0;
    em_hits    = '0;
    cval       = base_rdata;
    if (cnt_r != '0 && neg_sum < SW'(cnt_r)) begin
      cval = '0;
    end
    unique case (state_q)
      ogua_pkg::BK_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = '0;
      end
      ogua_pkg::BK_IDLE: begin
        pop_o = !empty_i;
      end
      ogua_pkg::BK_EXEC: begin
        unique case (cur_q.op)
          ogua_pkg::OP_NONE: emit = 1'b1;
          ogua_pkg::OP_LOAD: begin
            if (load_match) begin
              base_we = 1'b1;
              emit    = 1'b1;
            end else begin
              div_start = 1'b1;
            end
          end
          ogua_pkg::OP_UPDATE: st_re = 1'b1;
          ogua_pkg::OP_QUERY: begin
            st_re   = 1'b1;
            base_re = 1'b1;
          end
        endcase
      end
      ogua_pkg::BK_LOAD_DIV: begin
        emit = 1'b0;
      end
      ogua_pkg::BK_UPD_WR: begin
        emit = 1'b1;
        if (cnt_r == ogua_pkg::COUNT_MAX) begin
          em_status = ogua_pkg::ST_SATURATED;
        end else begin
          st_we = 1'b1;
        end
      end
      ogua_pkg::BK_QRY_EVAL: begin
        if (qry_div) begin
          div_start = 1'b1;
        end else begin
          emit    = 1'b1;
          em_comb = cval;
          em_free = (cval == ogua_pkg::FREE_VALUE) ? ogua_pkg::MARK_FREE
                                                   : ogua_pkg::MARK_OCCUPIED;
          em_hits = cnt_r;
        end
      end
      ogua_pkg::BK_QRY_DIV: begin
        emit    = div_done;
        em_comb = div_quot[VW-1:0];
        em_free = (div_quot == DW'(ogua_pkg::FREE_VALUE)) ? ogua_pkg::MARK_FREE
                                                          : ogua_pkg::MARK_OCCUPIED;
        em_hits = cnt_r;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ogua_pkg::BK_CLEAR;
      clr_q   <= '0;
      lx_q    <= '0;
      ly_q    <= '0;
      lw_q    <= '0;
      done_q  <= 1'b0;
      status_q <= ogua_pkg::ST_DONE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= emit;
      if (state_q == ogua_pkg::BK_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ogua_pkg::BK_LOAD_DIV && div_done) begin
        lx_q <= div_rem[8:0];
        ly_q <= div_quot[8:0];
        lw_q <= w_i;
      end
      if (base_we) begin
        if (lx_q + 9'd1 == w_i) begin
          lx_q <= '0;
          ly_q <= ly_q + 9'd1;
        end else begin
          lx_q <= lx_q + 9'd1;
        end
      end
      if (emit) begin
        status_q <= em_status;
        ready_q  <= cur_q.ready;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= cmd_i;
      addr_q <= addr_i;
    end
    if (emit) begin
      comb_q <= em_comb;
      free_q <= em_free;
      hits_q <= em_hits;
    end
  end

  assign clearing_o       = (state_q == ogua_pkg::BK_CLEAR);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign map_ready_o      = ready_q;
  assign combined_value_o = comb_q;
  assign free_mark_o      = free_q;
  assign hit_count_o      = hits_q;

  a_no_beat_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ogua_pkg::BK_CLEAR) |=> !done_q)
    else $error("result beat during clearing pass");

  a_free_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && comb_q == ogua_pkg::FREE_VALUE) |->
    (free_q == ogua_pkg::MARK_FREE && status_q == ogua_pkg::ST_DONE))
    else $error("combined value of 100 without free mark");

  a_hits_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && hits_q != '0) |-> (status_q == ogua_pkg::ST_DONE))
    else $error("hit count on a failed item");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ogua_pkg::BK_LOAD_DIV || state_q == ogua_pkg::BK_QRY_DIV))
    else $error("divider finished with no waiting state");

endmodule

// File: rtl/occupancy_grid_update_averager.sv
// ----------------------------------------------------------------------------
// occupancy_grid_update_averager
// Per-cell hit count and value sum over a grid, with averaged queries.
// ----------------------------------------------------------------------------
// usage
//   items enter on start when busy is low; one result beat per item is shown
//   on the result ports for one cycle with done_o, in item order
//   size registers sit on the apb port at 0 (width) and 4 (height)
//   patch updates do a read-modify-write of the statistics ram; queries
//   that take an average go through the shared divider, as do the first
//   load and a load after a width change
//   throughput: one item at a time in the back end, two-entry queue in front
//   reset: the whole statistics ram is swept to zero, busy stays high
//   meanwhile; apb writes are taken as ever
//   the receiver cannot stall: every beat must be taken as it appears
// ----------------------------------------------------------------------------
module occupancy_grid_update_averager #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action_i,
  input  logic signed [7:0] cell_value_i,
  input  logic              patch_first_i,
  input  logic signed [8:0] patch_x_i,
  input  logic signed [8:0] patch_y_i,
  input  logic [8:0]        patch_width_i,
  input  logic [8:0]        patch_height_i,
  input  logic [7:0]        query_x_i,
  input  logic [7:0]        query_y_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic              map_ready_o,
  output logic signed [7:0] combined_value_o,
  output logic [7:0]        free_mark_o,
  output logic [14:0]       hit_count_o
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int FW = (AW > ogua_pkg::POS_W) ? AW : ogua_pkg::POS_W;
  localparam int QW = $bits(ogua_pkg::cmd_t) + FW;

  logic [8:0]     width_q, height_q;
  logic           accept;
  logic           push, pop, q_empty, q_full, clearing;
  ogua_pkg::cmd_t f_cmd, b_cmd;
  logic [FW-1:0]  f_addr, b_addr;
  logic [8:0]     w;
  logic [QW-1:0]  q_out;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {23'd0, height_q} : {23'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        height_q <= pwdata[8:0];
      end else begin
        width_q <= pwdata[8:0];
      end
    end
  end

  assign busy   = q_full || clearing;
  assign accept = start && !busy;

  ogua_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .action_i       (action_i),
    .cell_value_i   (cell_value_i),
    .patch_first_i  (patch_first_i),
    .patch_x_i      (patch_x_i),
    .patch_y_i      (patch_y_i),
    .patch_width_i  (patch_width_i),
    .patch_height_i (patch_height_i),
    .query_x_i      (query_x_i),
    .query_y_i      (query_y_i),
    .map_width_i    (width_q),
    .map_height_i   (height_q),
    .push_o         (push),
    .cmd_o          (f_cmd),
    .addr_o         (f_addr),
    .w_o            (w)
  );

  ogua_queue #(.WIDTH(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_cmd, f_addr}),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign b_cmd  = q_out[QW-1:FW];
  assign b_addr = q_out[FW-1:0];

  ogua_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .cmd_i            (b_cmd),
    .addr_i           (b_addr),
    .w_i              (w),
    .pop_o            (pop),
    .clearing_o       (clearing),
    .done_o           (done_o),
    .status_o         (status_o),
    .map_ready_o      (map_ready_o),
    .combined_value_o (combined_value_o),
    .free_mark_o      (free_mark_o),
    .hit_count_o      (hit_count_o)
  );

endmodule
